@@ rtl/core/saturating_linear_range_map_defines.svh @@
// assertion macros for the saturating linear range map checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef SATURATING_LINEAR_RANGE_MAP_DEFINES_SVH
`define SATURATING_LINEAR_RANGE_MAP_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define SLRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define SLRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after a reset cycle
`define SLRM_ASSERT_AFTER_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/slrm_pkg.sv @@
// shared types and constants for the saturating linear range map
// no dependencies
`timescale 1ns / 1ps

package slrm_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int CFG_INDEX_W    = 2;

  // register reset values
  localparam int INPUT_LOW_RESET   = 0;
  localparam int INPUT_HIGH_RESET  = 4095;
  localparam int OUTPUT_LOW_RESET  = 0;
  localparam int OUTPUT_HIGH_RESET = 1000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INPUT_LOW   = 2'd0,
    CFG_INPUT_HIGH  = 2'd1,
    CFG_OUTPUT_LOW  = 2'd2,
    CFG_OUTPUT_HIGH = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    REGION_IN_RANGE  = 2'd0,
    REGION_BELOW     = 2'd1,
    REGION_ABOVE     = 2'd2,
    REGION_ZERO_SPAN = 2'd3
  } region_t;

  // control that travels with each item from cell to cell
  typedef struct packed {
    logic    valid;
    region_t region;
    logic    neg;
  } ctl_t;

endpackage

@@ rtl/core/slrm_front.sv @@
// front cells: span classification, offsets, then the full-width product
// depends on slrm_pkg
`timescale 1ns / 1ps

module slrm_front #(
  parameter int DATA_WIDTH = slrm_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [DATA_WIDTH-1:0] in_sample,
  output logic                         in_rdy,
  input  logic signed [DATA_WIDTH-1:0] input_low,
  input  logic signed [DATA_WIDTH-1:0] input_high,
  input  logic signed [DATA_WIDTH-1:0] output_low,
  input  logic signed [DATA_WIDTH-1:0] output_high,
  output slrm_pkg::ctl_t               out_ctl,
  output logic [2*DATA_WIDTH-1:0]      out_prod,
  input  logic                         out_rdy
);

  localparam int PW = 2 * DATA_WIDTH;

  // stage 1: classify and take differences
  logic                    v1_r, v1_nxt;
  slrm_pkg::region_t       region1_r, region1_nxt;
  logic                    neg1_r, neg1_nxt;
  logic [DATA_WIDTH-1:0]   dx1_r, dx1_nxt;
  logic [DATA_WIDTH-1:0]   dmag1_r, dmag1_nxt;
  // stage 2: product
  logic                    v2_r, v2_nxt;
  slrm_pkg::region_t       region2_r;
  logic                    neg2_r;
  logic [PW-1:0]           prod2_r, prod2_nxt;
  logic                    s2_rdy;

  assign s2_rdy = !v2_r || out_rdy;
  assign in_rdy = !v1_r || s2_rdy;
  assign v1_nxt = in_rdy ? in_valid : v1_r;
  assign v2_nxt = s2_rdy ? v1_r : v2_r;

  always_comb begin
    neg1_nxt  = output_high < output_low;
    dmag1_nxt = neg1_nxt ? DATA_WIDTH'(output_low - output_high)
                         : DATA_WIDTH'(output_high - output_low);
    dx1_nxt   = DATA_WIDTH'(in_sample - input_low);
    if (in_sample < input_low) begin
      region1_nxt = slrm_pkg::REGION_BELOW;
    end else if (in_sample > input_high) begin
      region1_nxt = slrm_pkg::REGION_ABOVE;
    end else if (input_high == input_low) begin
      region1_nxt = slrm_pkg::REGION_ZERO_SPAN;
    end else begin
      region1_nxt = slrm_pkg::REGION_IN_RANGE;
    end
  end

  assign prod2_nxt = PW'(dx1_r) * PW'(dmag1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_valid) begin
      region1_r <= region1_nxt;
      neg1_r    <= neg1_nxt;
      dx1_r     <= dx1_nxt;
      dmag1_r   <= dmag1_nxt;
    end
    if (s2_rdy && v1_r) begin
      region2_r <= region1_r;
      neg2_r    <= neg1_r;
      prod2_r   <= prod2_nxt;
    end
  end

  assign out_ctl.valid  = v2_r;
  assign out_ctl.region = region2_r;
  assign out_ctl.neg    = neg2_r;
  assign out_prod       = prod2_r;

endmodule

@@ rtl/core/slrm_div_cell.sv @@
// one restoring-division cell: produces one quotient bit per item
// depends on slrm_pkg
`timescale 1ns / 1ps

module slrm_div_cell #(
  parameter int DATA_WIDTH = slrm_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [DATA_WIDTH-1:0] span,
  input  slrm_pkg::ctl_t        in_ctl,
  input  logic [DATA_WIDTH-1:0] in_rem,
  input  logic [DATA_WIDTH-1:0] in_low,
  input  logic [DATA_WIDTH-1:0] in_quo,
  output logic                  in_rdy,
  output slrm_pkg::ctl_t        out_ctl,
  output logic [DATA_WIDTH-1:0] out_rem,
  output logic [DATA_WIDTH-1:0] out_low,
  output logic [DATA_WIDTH-1:0] out_quo,
  input  logic                  out_rdy
);

  logic                  v_r, v_nxt;
  slrm_pkg::region_t     region_r;
  logic                  neg_r;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] low_r;
  logic [DATA_WIDTH-1:0] quo_r;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  // shift in the next dividend bit, subtract the divisor if it fits
  assign trial   = {in_rem, in_low[DATA_WIDTH-1]};
  assign diff    = trial - {1'b0, span};
  assign ge      = trial >= {1'b0, span};
  assign rem_nxt = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];

  assign in_rdy = !v_r || out_rdy;
  assign v_nxt  = in_rdy ? in_ctl.valid : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ctl.valid) begin
      region_r <= in_ctl.region;
      neg_r    <= in_ctl.neg;
      rem_r    <= rem_nxt;
      low_r    <= {in_low[DATA_WIDTH-2:0], 1'b0};
      quo_r    <= {in_quo[DATA_WIDTH-2:0], ge};
    end
  end

  assign out_ctl.valid  = v_r;
  assign out_ctl.region = region_r;
  assign out_ctl.neg    = neg_r;
  assign out_rem        = rem_r;
  assign out_low        = low_r;
  assign out_quo        = quo_r;

endmodule

@@ rtl/core/slrm_back.sv @@
// back cell: applies the quotient to the output span, or saturates to an output bound, and holds the result
// depends on slrm_pkg
`timescale 1ns / 1ps

module slrm_back #(
  parameter int DATA_WIDTH = slrm_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [DATA_WIDTH-1:0] output_low,
  input  logic signed [DATA_WIDTH-1:0] output_high,
  input  slrm_pkg::ctl_t               in_ctl,
  input  logic [DATA_WIDTH-1:0]        in_quo,
  output logic                         in_rdy,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_mapped,
  output logic [1:0]                   out_region,
  input  logic                         out_stall
);

  logic                  v_r, v_nxt;
  logic [DATA_WIDTH-1:0] mapped_r, mapped_nxt;
  slrm_pkg::region_t     region_r;
  logic [DATA_WIDTH-1:0] interp;

  assign interp = in_ctl.neg ? DATA_WIDTH'(output_low - in_quo)
                             : DATA_WIDTH'(output_low + in_quo);

  always_comb begin
    case (in_ctl.region)
      slrm_pkg::REGION_IN_RANGE: mapped_nxt = interp;
      slrm_pkg::REGION_ABOVE:    mapped_nxt = output_high;
      default:                   mapped_nxt = output_low;
    endcase
  end

  assign in_rdy = !v_r || !out_stall;
  assign v_nxt  = in_rdy ? in_ctl.valid : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ctl.valid) begin
      mapped_r <= mapped_nxt;
      region_r <= in_ctl.region;
    end
  end

  assign out_valid  = v_r;
  assign out_mapped = mapped_r;
  assign out_region = region_r;

endmodule

@@ rtl/core/saturating_linear_range_map.sv @@
// top level of the saturating linear range map: config registers and the cell chain
// depends on slrm_pkg, slrm_front, slrm_div_cell, slrm_back
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall   in_sample
//   out      output     out_valid/out_stall out_mapped, out_region
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// one sample enters per cycle while in_stall is low; the chain is two front
// cells, one division cell per quotient bit, one output cell
// reset is synchronous, active low: clears all valid bits, loads register defaults
// each cell moves its item on whenever the next cell is empty or moving, so
// bubbles collapse and samples are still taken while a result waits on out_stall
// cfg_ready is always high; registers are meant to be written while idle
`timescale 1ns / 1ps

module saturating_linear_range_map #(
  parameter int DATA_WIDTH = slrm_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // sample input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [DATA_WIDTH-1:0]     in_sample,
  // mapped result
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [DATA_WIDTH-1:0]     out_mapped,
  output logic [1:0]                       out_region,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slrm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]            cfg_data
);

  // calibration registers
  logic signed [DATA_WIDTH-1:0] input_low_r;
  logic signed [DATA_WIDTH-1:0] input_high_r;
  logic signed [DATA_WIDTH-1:0] output_low_r;
  logic signed [DATA_WIDTH-1:0] output_high_r;

  // divisor, only meaningful for in-range items where high > low
  logic [DATA_WIDTH-1:0] span;

  // links along the chain; index i feeds division cell i
  logic                  front_rdy;
  logic [2*DATA_WIDTH-1:0] prod;
  slrm_pkg::ctl_t        link_ctl [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] link_rem [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] link_low [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] link_quo [DATA_WIDTH+1];
  logic                  link_rdy [DATA_WIDTH+1];

  assign cfg_ready = 1'b1;

  // register writes; unknown indexes would be ignored by the default arm
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_low_r   <= DATA_WIDTH'(slrm_pkg::INPUT_LOW_RESET);
      input_high_r  <= DATA_WIDTH'(slrm_pkg::INPUT_HIGH_RESET);
      output_low_r  <= DATA_WIDTH'(slrm_pkg::OUTPUT_LOW_RESET);
      output_high_r <= DATA_WIDTH'(slrm_pkg::OUTPUT_HIGH_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slrm_pkg::CFG_INPUT_LOW:   input_low_r   <= cfg_data;
        slrm_pkg::CFG_INPUT_HIGH:  input_high_r  <= cfg_data;
        slrm_pkg::CFG_OUTPUT_LOW:  output_low_r  <= cfg_data;
        slrm_pkg::CFG_OUTPUT_HIGH: output_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared divisor; user keeps registers static while items are in flight, unchecked
  assign span = DATA_WIDTH'(input_high_r - input_low_r);

  assign in_stall = !front_rdy;

  // classification and product
  slrm_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_sample   (in_sample),
    .in_rdy      (front_rdy),
    .input_low   (input_low_r),
    .input_high  (input_high_r),
    .output_low  (output_low_r),
    .output_high (output_high_r),
    .out_ctl     (link_ctl[0]),
    .out_prod    (prod),
    .out_rdy     (link_rdy[0])
  );

  // product high half is already below the span, so DATA_WIDTH steps suffice
  assign link_rem[0] = prod[2*DATA_WIDTH-1:DATA_WIDTH];
  assign link_low[0] = prod[DATA_WIDTH-1:0];
  assign link_quo[0] = '0;

  // one cell per quotient bit, msb first
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_div
    slrm_div_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .span    (span),
      .in_ctl  (link_ctl[i]),
      .in_rem  (link_rem[i]),
      .in_low  (link_low[i]),
      .in_quo  (link_quo[i]),
      .in_rdy  (link_rdy[i]),
      .out_ctl (link_ctl[i+1]),
      .out_rem (link_rem[i+1]),
      .out_low (link_low[i+1]),
      .out_quo (link_quo[i+1]),
      .out_rdy (link_rdy[i+1])
    );
  end

  // offset into the output span and output register
  slrm_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .output_low  (output_low_r),
    .output_high (output_high_r),
    .in_ctl      (link_ctl[DATA_WIDTH]),
    .in_quo      (link_quo[DATA_WIDTH]),
    .in_rdy      (link_rdy[DATA_WIDTH]),
    .out_valid   (out_valid),
    .out_mapped  (out_mapped),
    .out_region  (out_region),
    .out_stall   (out_stall)
  );

  // the last remainder and dividend bits are spent; nothing downstream reads them
  logic unused_tail;
  assign unused_tail = ^{link_rem[DATA_WIDTH], link_low[DATA_WIDTH]};

endmodule

@@ rtl/core/slrm_checker.sv @@
// port-level checks for the saturating linear range map, bound to the top level
// depends on slrm_pkg, saturating_linear_range_map_defines.svh
`timescale 1ns / 1ps
`include "saturating_linear_range_map_defines.svh"

module slrm_checker #(
  parameter int DATA_WIDTH = slrm_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [DATA_WIDTH-1:0] out_mapped,
  input logic [1:0]            out_region,
  input logic                  cfg_ready
);

  // a held result keeps its value
  `SLRM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_mapped) && $stable(out_region), "stalled result changed")

  // an empty output cell means the whole chain can take a transfer
  `SLRM_ASSERT_NOW(a_empty_accepts, !out_valid, !in_stall, "input stalled with empty output")

  // no result comes out of reset
  `SLRM_ASSERT_AFTER_RST(a_rst_clears, !out_valid, "result valid right after reset")

  // config port never backs up
  `SLRM_ASSERT_NOW(a_cfg_ready, in_valid || !in_valid, cfg_ready, "config port not ready")

endmodule

bind saturating_linear_range_map slrm_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_slrm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_mapped (out_mapped),
  .out_region (out_region),
  .cfg_ready  (cfg_ready)
);
